// File: rtl/json_string_unescape_defines.svh
// ----------------------------------------------------------------------------
// json_string_unescape assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH

// same-cycle implication
`define JSU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and character constants shared by the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// most bytes one item can produce
	localparam int MaxOut = 5;
	localparam int CntW   = $clog2(MaxOut + 1);

	// escape characters
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_U      = 8'h75;

	// control bytes the simple escapes turn into
	localparam logic [7:0] CTL_LF  = 8'h0A;
	localparam logic [7:0] CTL_CR  = 8'h0D;
	localparam logic [7:0] CTL_TAB = 8'h09;
	localparam logic [7:0] CTL_BS  = 8'h08;
	localparam logic [7:0] CTL_FF  = 8'h0C;

	// utf-8 framing
	localparam logic [7:0]  Utf8Lead2 = 8'hC0;
	localparam logic [7:0]  Utf8Lead3 = 8'hE0;
	localparam logic [7:0]  Utf8Cont  = 8'h80;
	localparam logic [15:0] Utf8Lim1  = 16'h0080;
	localparam logic [15:0] Utf8Lim2  = 16'h0800;

	// escape progress: how many bytes of an escape are held
	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_BSLASH = 3'd1,
		ST_U      = 3'd2,
		ST_HEX1   = 3'd3,
		ST_HEX2   = 3'd4,
		ST_HEX3   = 3'd5
	} jsu_pend_t;

	// the bytes one item produces, in output order
	typedef struct packed {
		logic [MaxOut-1:0][7:0] bytes;
		logic [CntW-1:0]        count;
		logic                   last;
	} jsu_res_t;

endpackage

// File: rtl/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// Escaped byte channel: valid/ready handshake with byte and end-of-string flag.
// ----------------------------------------------------------------------------
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_final;

	modport source (output valid, output in_byte, output is_final, input ready);
	modport sink (input valid, input in_byte, input is_final, output ready);
endinterface

// File: rtl/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// Unescaped byte channel: valid/ready handshake with byte and last-byte flag.
// ----------------------------------------------------------------------------
interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_final;

	modport source (output valid, output out_byte, output out_final, input ready);
	modport sink (input valid, input out_byte, input out_final, output ready);
endinterface

// File: rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Escape state and buffered hex bytes; turns one raw byte into its output list.
// ----------------------------------------------------------------------------
module jsu_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic [7:0]        data,
	input  logic              fin,
	output jsu_pkg::jsu_res_t res,
	output jsu_pkg::jsu_pend_t state
);
	import jsu_pkg::*;

	typedef struct packed {
		jsu_res_t  res;
		jsu_pend_t pc;
	} mini_t;

	jsu_pend_t  pc_q;
	jsu_pend_t  pc_d;
	logic [7:0] hex_q [3];
	logic       hex_we;
	logic [1:0] hex_idx;

	// append one byte, dropping anything past the last slot
	function automatic jsu_res_t push(jsu_res_t r, logic [7:0] b);
		jsu_res_t o;
		o = r;
		if (o.count < CntW'(MaxOut)) begin
			o.bytes[o.count] = b;
			o.count = o.count + CntW'(1);
		end
		return o;
	endfunction

	// {hit, byte} for the single-character escapes
	function automatic logic [8:0] simple_map(logic [7:0] c);
		logic [8:0] m;
		m = '0;
		unique case (c)
			CH_QUOTE:  m = {1'b1, CH_QUOTE};
			CH_BSLASH: m = {1'b1, CH_BSLASH};
			CH_SLASH:  m = {1'b1, CH_SLASH};
			CH_N:      m = {1'b1, CTL_LF};
			CH_R:      m = {1'b1, CTL_CR};
			CH_T:      m = {1'b1, CTL_TAB};
			CH_B:      m = {1'b1, CTL_BS};
			CH_F:      m = {1'b1, CTL_FF};
			default:   m = '0;
		endcase
		return m;
	endfunction

	// {valid, nibble} of a hex digit
	function automatic logic [4:0] hex_digit(logic [7:0] c);
		logic [4:0] d;
		d = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			d = {1'b1, c[3:0] + 4'd9};
		end
		return d;
	endfunction

	// one byte through the plain/backslash/'u' part of the escape machine
	function automatic mini_t mini_step(mini_t m, logic [7:0] b, logic last);
		mini_t      o;
		logic [8:0] se;
		o  = m;
		se = simple_map(b);
		unique case (m.pc)
			ST_BSLASH: begin
				if (se[8]) begin
					o.res = push(o.res, se[7:0]);
					o.pc  = ST_IDLE;
				end else if (b == CH_U && !last) begin
					o.pc = ST_U;
				end else begin
					o.res = push(o.res, CH_BSLASH);
					o.res = push(o.res, b);
					o.pc  = ST_IDLE;
				end
			end
			ST_U: begin
				// only reached on the final byte of a replay
				o.res = push(o.res, CH_BSLASH);
				o.res = push(o.res, CH_U);
				o.res = push(o.res, b);
				o.pc  = ST_IDLE;
			end
			default: begin
				if (b == CH_BSLASH && !last) begin
					o.pc = ST_BSLASH;
				end else begin
					o.res = push(o.res, b);
				end
			end
		endcase
		return o;
	endfunction

	// next state and output list
	always_comb begin
		mini_t       m;
		logic [1:0]  len;
		logic [4:0]  dg [4];
		logic [15:0] cp;

		m.res      = '0;
		m.res.last = fin;
		m.pc       = ST_IDLE;
		pc_d       = pc_q;
		hex_we     = 1'b0;
		hex_idx    = 2'(pc_q - ST_U);
		len        = 2'(pc_q - ST_BSLASH);
		dg[0]      = hex_digit(hex_q[0]);
		dg[1]      = hex_digit(hex_q[1]);
		dg[2]      = hex_digit(hex_q[2]);
		dg[3]      = hex_digit(data);
		cp         = '0;

		unique case (pc_q)
			ST_U, ST_HEX1, ST_HEX2: begin
				if (!fin) begin
					hex_we = 1'b1;
					pc_d   = jsu_pend_t'(pc_q + 3'd1);
				end else begin
					// cut short: backslash, 'u', then the held bytes and this byte replayed
					m.res = push(m.res, CH_BSLASH);
					m.res = push(m.res, CH_U);
					for (int k = 0; k < 3; k++) begin
						if (k < int'(len)) begin
							m = mini_step(m, (k == int'(len) - 1) ? data : hex_q[k],
								k == int'(len) - 1);
						end
					end
					pc_d = ST_IDLE;
				end
			end
			ST_HEX3: begin
				// leading run of hex digits
				priority if (!dg[0][4]) begin
					cp = '0;
				end else if (!dg[1][4]) begin
					cp = {12'd0, dg[0][3:0]};
				end else if (!dg[2][4]) begin
					cp = {8'd0, dg[0][3:0], dg[1][3:0]};
				end else if (!dg[3][4]) begin
					cp = {4'd0, dg[0][3:0], dg[1][3:0], dg[2][3:0]};
				end else begin
					cp = {dg[0][3:0], dg[1][3:0], dg[2][3:0], dg[3][3:0]};
				end
				// utf-8 encode
				priority if (cp < Utf8Lim1) begin
					m.res = push(m.res, cp[7:0]);
				end else if (cp < Utf8Lim2) begin
					m.res = push(m.res, Utf8Lead2 | {3'd0, cp[10:6]});
					m.res = push(m.res, Utf8Cont | {2'd0, cp[5:0]});
				end else begin
					m.res = push(m.res, Utf8Lead3 | {4'd0, cp[15:12]});
					m.res = push(m.res, Utf8Cont | {2'd0, cp[11:6]});
					m.res = push(m.res, Utf8Cont | {2'd0, cp[5:0]});
				end
				pc_d = ST_IDLE;
			end
			default: begin
				m.pc = (pc_q == ST_BSLASH) ? ST_BSLASH : ST_IDLE;
				m    = mini_step(m, data, fin);
				pc_d = m.pc;
			end
		endcase

		res = m.res;
	end

	// escape state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (adv) begin
			pc_q <= pc_d;
		end
	end

	// held hex bytes
	always_ff @(posedge clk) begin
		if (adv && hex_we) begin
			hex_q[hex_idx] <= data;
		end
	end

	assign state = pc_q;

endmodule

// File: rtl/jsu_outbuf.sv
// ----------------------------------------------------------------------------
// jsu_outbuf
// Result register: holds one item's output bytes and shifts them out in order.
// ----------------------------------------------------------------------------
module jsu_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  jsu_pkg::jsu_res_t res,
	output logic              can_load,
	jsu_out_if.source         plain
);
	import jsu_pkg::*;

	logic [MaxOut-1:0][7:0] bytes_q;
	logic [CntW-1:0]        cnt_q;
	logic                   last_q;
	logic                   take;

	// output side
	assign take            = plain.valid && plain.ready;
	assign plain.valid     = (cnt_q != '0);
	assign plain.out_byte  = bytes_q[0];
	assign plain.out_final = last_q && (cnt_q == CntW'(1));

	// empty, or emptying on this edge
	assign can_load = (cnt_q == '0) || ((cnt_q == CntW'(1)) && take);

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (take) begin
			cnt_q <= cnt_q - CntW'(1);
		end
	end

	// byte slots, head at index zero
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
			last_q  <= res.last;
		end else if (take) begin
			for (int i = 0; i < MaxOut - 1; i++) begin
				bytes_q[i] <= bytes_q[i + 1];
			end
		end
	end

endmodule

// File: rtl/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape
// JSON string body unescaper with \u to UTF-8 conversion.
// ----------------------------------------------------------------------------
// Usage:
//   escaped carries raw string-body bytes, is_final set on the last byte of a
//   string. plain carries the unescaped bytes, out_final set on the last byte
//   produced for a final input item.
//   An accepted item is held in the input register, decoded there and written
//   into the result register once that can load; the result register then
//   offers its first byte on plain. One item per cycle while each yields at
//   most one byte and plain is ready. An item yielding several bytes (up to
//   five, for a cut-short \u escape) holds the result register until plain
//   has taken them all, since plain moves one byte per cycle while ready;
//   escaped.ready drops while the input register waits behind it. Bytes that
//   start an escape yield nothing and pass at full rate while the result
//   register is free. When plain is stalled the result register holds, the
//   input register fills, and escaped.ready goes low until bytes drain.
//   Reset empties both registers and drops any partial escape.
// ----------------------------------------------------------------------------
`include "json_string_unescape_defines.svh"

module json_string_unescape (
	input logic       clk,
	input logic       arst_n,
	jsu_in_if.sink    escaped,
	jsu_out_if.source plain
);
	import jsu_pkg::*;

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;
	logic       adv;
	logic       can_load;
	jsu_res_t   res;
	jsu_pend_t  state;

	// input register moves on when the result register takes its item
	assign adv           = v_s1 && can_load;
	assign escaped.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (escaped.ready) begin
			v_s1 <= escaped.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (escaped.valid && escaped.ready) begin
			byte_s1 <= escaped.in_byte;
			fin_s1  <= escaped.is_final;
		end
	end

	// escape decode
	jsu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.data   (byte_s1),
		.fin    (fin_s1),
		.res    (res),
		.state  (state)
	);

	// result register
	jsu_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv),
		.res      (res),
		.can_load (can_load),
		.plain    (plain)
	);

	// checks
	`JSU_ASSERT_NXT(a_hold_s1, v_s1 && !adv, v_s1 && $stable(byte_s1) && $stable(fin_s1), "input register item changed while blocked")
	`JSU_ASSERT_NXT(a_final_idle, adv && fin_s1, state == ST_IDLE, "escape still pending after end of string")
	`JSU_ASSERT_IMP(a_res_count, adv, res.count <= CntW'(MaxOut), "item output list overflows result register")

endmodule

// File: test/json_string_unescape_tb.sv
// ----------------------------------------------------------------------------
// json_string_unescape_tb
// Drives escaped JSON string bodies through the unescaper, one byte per item,
// with random sender gaps and receiver stalls. An in-bench model of the escape
// decoder predicts every output byte and its last-byte flag, and a checker
// compares each accepted output item against the oldest prediction.
// ----------------------------------------------------------------------------
module json_string_unescape_tb;
	import jsu_pkg::*;

	// one predicted output item
	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} plain_byte_t;

	// receiver stall patterns
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_BURSTY
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	jsu_in_if  escaped ();
	jsu_out_if plain ();

	json_string_unescape u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.escaped (escaped),
		.plain   (plain)
	);

	// decoder model state
	logic [7:0]  held_bytes [5];
	int          held_cnt;
	int          step_n;
	plain_byte_t plain_due [$];

	// sender pacing
	int burst_left;
	int idle_due;
	bit drive_hi;
	bit no_gaps;

	// checker and receiver state
	int          fails = 0;
	plain_byte_t chk_due;
	rx_mode_t    rx_mode = RX_OPEN;
	int          rx_phase = 0;
	int          rx_tick = 0;

	logic [7:0] simple_tab [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_N,
		CH_R, CH_T, CH_B, CH_F};

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	initial begin
		#1000000;
		$display("FAILURE");
		$finish;
	end

	// byte a simple escape turns into, or -1
	function automatic int simple_escape(input logic [7:0] b);
		case (b)
			CH_QUOTE:  return CH_QUOTE;
			CH_BSLASH: return CH_BSLASH;
			CH_SLASH:  return CH_SLASH;
			CH_N:      return CTL_LF;
			CH_R:      return CTL_CR;
			CH_T:      return CTL_TAB;
			CH_B:      return CTL_BS;
			CH_F:      return CTL_FF;
			default:   return -1;
		endcase
	endfunction

	// value of a hex digit, or -1
	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
		if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
		if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
		return -1;
	endfunction

	// ascii hex digit for a nibble
	function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
		if (nib < 4'd10) return 8'h30 + nib;
		return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
	endfunction

	// queue one predicted byte, at most five per item
	function automatic void add_byte(input logic [7:0] v);
		plain_byte_t pb;
		if (step_n < MaxOut) begin
			pb.data = v;
			pb.fin  = 1'b0;
			plain_due.push_back(pb);
			step_n++;
		end
	endfunction

	// predict the output bytes for one accepted input item
	task automatic predict_unescape(input logic [7:0] raw, input logic fin);
		logic [7:0]  replay [8];
		logic [7:0]  hexq [4];
		logic [7:0]  b;
		logic [15:0] cp;
		plain_byte_t tail;
		int          rn, rp, cnt, k, esc, nib;
		bit          last, run;
		rn = 1;
		rp = 0;
		replay[0] = raw;
		step_n = 0;
		while (rp < rn) begin
			b = replay[rp];
			last = fin && (rp == rn - 1);
			if (held_cnt == 0) begin
				// plain byte or start of an escape
				if (b == CH_BSLASH && !last) begin
					held_bytes[0] = b;
					held_cnt = 1;
				end else begin
					add_byte(b);
				end
				rp++;
			end else if (held_cnt == 1) begin
				esc = simple_escape(b);
				if (esc >= 0) begin
					add_byte(esc[7:0]);
					held_cnt = 0;
					rp++;
				end else if (b == CH_U && !last) begin
					held_bytes[1] = b;
					held_cnt = 2;
					rp++;
				end else begin
					// unknown escape: backslash out, byte handled again
					add_byte(CH_BSLASH);
					held_cnt = 0;
				end
			end else if (held_cnt == 5) begin
				// fourth hex byte: decode the leading hex run
				hexq[0] = held_bytes[2];
				hexq[1] = held_bytes[3];
				hexq[2] = held_bytes[4];
				hexq[3] = b;
				cp = 16'h0;
				run = 1'b1;
				for (k = 0; k < 4; k++) begin
					nib = hex_nibble(hexq[k]);
					if (nib < 0) run = 1'b0;
					if (run) cp = {cp[11:0], nib[3:0]};
				end
				if (cp < Utf8Lim1) begin
					add_byte(cp[7:0]);
				end else if (cp < Utf8Lim2) begin
					add_byte(Utf8Lead2 | {3'b000, cp[10:6]});
					add_byte(Utf8Cont | {2'b00, cp[5:0]});
				end else begin
					add_byte(Utf8Lead3 | {4'b0000, cp[15:12]});
					add_byte(Utf8Cont | {2'b00, cp[11:6]});
					add_byte(Utf8Cont | {2'b00, cp[5:0]});
				end
				held_cnt = 0;
				rp++;
			end else if (!last) begin
				held_bytes[held_cnt] = b;
				held_cnt++;
				rp++;
			end else begin
				// cut short by the end: backslash out, replay the rest
				cnt = held_cnt;
				add_byte(CH_BSLASH);
				for (k = 1; k < cnt; k++) replay[k - 1] = held_bytes[k];
				replay[cnt - 1] = b;
				rn = cnt;
				rp = 0;
				held_cnt = 0;
			end
		end
		if (fin && step_n > 0) begin
			tail = plain_due.pop_back();
			tail.fin = 1'b1;
			plain_due.push_back(tail);
		end
	endtask

	// send one item, keeping valid high across a burst
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (idle_due > 0) begin
			repeat (idle_due) @(posedge clk);
			idle_due = 0;
		end
		escaped.valid    <= 1'b1;
		escaped.in_byte  <= b;
		escaped.is_final <= fin;
		drive_hi = 1'b1;
		do @(posedge clk); while (!escaped.ready);
		predict_unescape(b, fin);
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (no_gaps || $urandom_range(0, 3) == 0) idle_due = 0;
			else idle_due = $urandom_range(1, 6);
			if (idle_due > 0) begin
				escaped.valid <= 1'b0;
				drive_hi = 1'b0;
			end
		end
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		if (rx_phase == 0) begin
			rx_mode  = rx_mode_t'($urandom_range(0, 3));
			rx_phase = $urandom_range(20, 80);
		end
		rx_phase--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:   plain.ready <= 1'b1;
			RX_COIN:   plain.ready <= $urandom_range(0, 1);
			RX_SPARSE: plain.ready <= (rx_tick % 4) == 0;
			default:   plain.ready <= (rx_tick % 16) >= 12;
		endcase
	end

	// compare each output item with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && plain.valid && plain.ready) begin
			if (plain_due.size() == 0) begin
				$error("unexpected output item: out_byte %02h out_final %0b",
					plain.out_byte, plain.out_final);
				fails++;
			end else begin
				chk_due = plain_due.pop_front();
				if (plain.out_byte !== chk_due.data) begin
					$error("out_byte: expected %02h, got %02h", chk_due.data,
						plain.out_byte);
					fails++;
				end
				if (plain.out_final !== chk_due.fin) begin
					$error("out_final: expected %0b, got %0b", chk_due.fin,
						plain.out_final);
					fails++;
				end
			end
		end
	end

	// every simple escape, the last one ending the string
	task automatic test_simple_escapes();
		int i;
		for (i = 0; i < 8; i++) begin
			send_byte(CH_BSLASH, 1'b0);
			send_byte(simple_tab[i], i == 7);
		end
	endtask

	// unknown escape with the top byte value as final
	task automatic test_unknown_escape();
		send_byte(CH_BSLASH, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	// backslash as the only and final byte
	task automatic test_lone_backslash();
		send_byte(CH_BSLASH, 1'b1);
	endtask

	// unicode escape cut short by a zero final byte
	task automatic test_cut_short();
		send_byte(CH_BSLASH, 1'b0);
		send_byte(CH_U, 1'b0);
		send_byte("0", 1'b0);
		send_byte(8'h00, 1'b1);
	endtask

	// quote and backslash stop the hex run, fourth hex byte is final
	task automatic test_unicode_hex_stop();
		send_byte(CH_BSLASH, 1'b0);
		send_byte(CH_U, 1'b0);
		send_byte("7", 1'b0);
		send_byte(CH_QUOTE, 1'b0);
		send_byte(CH_BSLASH, 1'b0);
		send_byte("0", 1'b1);
	endtask

	// random strings of escapes, some cut short, plus raw noise
	task automatic test_random_strings();
		logic [7:0]  text [$];
		logic [15:0] cp;
		int          sent, i, nseg, seg, kind, drop, pos, k;
		bit          last_uni;
		sent = 0;
		while (sent < 90) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				// raw noise, final at random
				nseg = $urandom_range(1, 8);
				for (i = 0; i < nseg; i++) begin
					send_byte($urandom_range(0, 255), $urandom_range(0, 3) == 0);
					sent++;
				end
			end else begin
				text.delete();
				last_uni = 1'b0;
				nseg = $urandom_range(1, 5);
				for (seg = 0; seg < nseg; seg++) begin
					kind = $urandom_range(0, 9);
					last_uni = 1'b0;
					if (kind <= 3) begin
						text.push_back($urandom_range(0, 255));
					end else if (kind <= 5) begin
						text.push_back(CH_BSLASH);
						text.push_back(simple_tab[$urandom_range(0, 7)]);
					end else if (kind <= 8) begin
						// unicode escape in one of the three utf-8 lengths
						case ($urandom_range(0, 2))
							0:       cp = $urandom_range(16'h0000, 16'h007F);
							1:       cp = $urandom_range(16'h0080, 16'h07FF);
							default: cp = $urandom_range(16'h0800, 16'hFFFF);
						endcase
						text.push_back(CH_BSLASH);
						text.push_back(CH_U);
						for (k = 3; k >= 0; k--)
							text.push_back(hex_char(cp[k*4 +: 4], $urandom_range(0, 1)));
						if ($urandom_range(0, 4) == 0) begin
							// break the hex run
							pos = text.size() - 4 + $urandom_range(0, 3);
							case ($urandom_range(0, 2))
								0:       text[pos] = CH_BSLASH;
								1:       text[pos] = CH_QUOTE;
								default: text[pos] = $urandom_range(0, 255);
							endcase
						end
						last_uni = 1'b1;
					end else begin
						text.push_back(CH_BSLASH);
						text.push_back($urandom_range(0, 255));
					end
				end
				// end the string inside the last unicode escape
				if (last_uni && $urandom_range(0, 3) == 0) begin
					drop = $urandom_range(1, 5);
					for (k = 0; k < drop; k++) void'(text.pop_back());
				end
				for (i = 0; i < text.size(); i++) begin
					send_byte(text[i], i == text.size() - 1);
					sent++;
				end
			end
		end
		no_gaps = 1'b0;
	endtask

	// drain and report
	task automatic finish_run();
		if (drive_hi) begin
			escaped.valid <= 1'b0;
			drive_hi = 1'b0;
		end
		while (plain_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (fails == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	endtask

	// main sequence
	initial begin
		arst_n           = 1'b0;
		escaped.valid    = 1'b0;
		escaped.in_byte  = 8'h00;
		escaped.is_final = 1'b0;
		held_cnt         = 0;
		foreach (held_bytes[i]) held_bytes[i] = 8'h00;
		step_n     = 0;
		burst_left = 0;
		idle_due   = 0;
		drive_hi   = 1'b0;
		no_gaps    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_simple_escapes();
		test_unknown_escape();
		test_lone_backslash();
		test_cut_short();
		test_unicode_hex_stop();
		test_random_strings();
		finish_run();
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/jsu_decode.sv
rtl/jsu_outbuf.sv
rtl/json_string_unescape.sv
test/json_string_unescape_tb.sv
